// ===== src/hfte_pkg.sv =====
package hfte_pkg;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 48;

	localparam logic [CFG_IDX_W-1:0] REG_DEST_CS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_CS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_ID = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_ID  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CTRL    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PID     = 3'd5;

	localparam logic [7:0]  CTRL_RESET = 8'h03;
	localparam logic [7:0]  PID_RESET  = 8'hF0;

	// line coding
	localparam logic [7:0]  FLAG_OCTET = 8'h7E;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'h8408;
	localparam logic [2:0]  STUFF_RUN  = 3'd5;

	// queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;

	typedef enum logic [1:0] {
		ACT_FLAG = 2'd0,
		ACT_HDR  = 2'd1,
		ACT_DATA = 2'd2,
		ACT_END  = 2'd3
	} action_t;

	// one octet job for the back end
	typedef enum logic [2:0] {
		TK_FLAG   = 3'd0,
		TK_OCT    = 3'd1,
		TK_FCS_LO = 3'd2,
		TK_FCS_HI = 3'd3,
		TK_END    = 3'd4
	} tk_kind_t;

	typedef struct packed {
		tk_kind_t   kind;
		logic [7:0] octet;
	} tk_word_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_OPEN,
		BK_BITS,
		BK_STUFF,
		BK_PAD
	} bk_state_t;

	// octet to shift out for a job, given the running CRC
	function automatic logic [7:0] tk_octet(tk_word_t tk, logic [15:0] crc);
		logic [7:0] r;
		case (tk.kind)
			TK_FLAG,
			TK_END:    r = FLAG_OCTET;
			TK_OCT:    r = tk.octet;
			TK_FCS_LO: r = ~crc[7:0];
			TK_FCS_HI: r = ~crc[15:8];
			default:   r = tk.octet;
		endcase
		return r;
	endfunction

endpackage

// ===== src/hfte_front.sv =====
module hfte_front #(
	parameter int CALLSIGN_CHARS = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [hfte_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hfte_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,
	input  logic [1:0]                    s_tuser,
	input  logic                          q_full,
	output logic                          q_push,
	output hfte_pkg::tk_word_t            q_tk
);
	import hfte_pkg::*;

	localparam int HDR_OCTETS = 2 * CALLSIGN_CHARS + 4;
	localparam int IDX_W      = $clog2(HDR_OCTETS);

	localparam logic [IDX_W-1:0] I_DEST_ID = IDX_W'(CALLSIGN_CHARS);
	localparam logic [IDX_W-1:0] I_SRC0    = IDX_W'(CALLSIGN_CHARS + 1);
	localparam logic [IDX_W-1:0] I_SRC_ID  = IDX_W'(2 * CALLSIGN_CHARS + 1);
	localparam logic [IDX_W-1:0] I_CTRL    = IDX_W'(2 * CALLSIGN_CHARS + 2);
	localparam logic [IDX_W-1:0] I_HDR_END = IDX_W'(HDR_OCTETS - 1);

	logic [47:0]      dest_cs_q;
	logic [47:0]      src_cs_q;
	logic [7:0]       dest_id_q;
	logic [7:0]       src_id_q;
	logic [7:0]       ctrl_q;
	logic [7:0]       pid_q;

	logic             busy_q;
	action_t          cmd_q;
	logic [7:0]       data_q;
	logic [IDX_W-1:0] idx_q;

	logic [2:0]       ch_sel;
	logic [7:0]       hdr_oct;
	logic             tk_last;
	logic             accept;

	// character j of a callsign (first in top byte), shifted left one bit
	function automatic logic [7:0] cs_char(logic [47:0] cs, logic [2:0] j);
		logic [47:0] t;
		t = cs >> {3'd5 - j, 3'b000};
		return {t[6:0], 1'b0};
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_cs_q <= '0;
			src_cs_q  <= '0;
			dest_id_q <= '0;
			src_id_q  <= '0;
			ctrl_q    <= CTRL_RESET;
			pid_q     <= PID_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEST_CS: dest_cs_q <= cfg_data;
				REG_SRC_CS:  src_cs_q  <= cfg_data;
				REG_DEST_ID: dest_id_q <= cfg_data[7:0];
				REG_SRC_ID:  src_id_q  <= cfg_data[7:0];
				REG_CTRL:    ctrl_q    <= cfg_data[7:0];
				REG_PID:     pid_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// header octet for the current index
	always_comb begin
		ch_sel = (idx_q < I_DEST_ID) ? idx_q[2:0] : 3'(idx_q - I_SRC0);
		if (idx_q < I_DEST_ID)
			hdr_oct = cs_char(dest_cs_q, ch_sel);
		else if (idx_q == I_DEST_ID)
			hdr_oct = dest_id_q;
		else if (idx_q < I_SRC_ID)
			hdr_oct = cs_char(src_cs_q, ch_sel);
		else if (idx_q == I_SRC_ID)
			hdr_oct = src_id_q;
		else if (idx_q == I_CTRL)
			hdr_oct = ctrl_q;
		else
			hdr_oct = pid_q;
	end

	// expand the held command into octet jobs
	always_comb begin
		q_tk.kind  = TK_FLAG;
		q_tk.octet = '0;
		tk_last    = 1'b1;
		case (cmd_q)
			ACT_FLAG: begin
				q_tk.kind = TK_FLAG;
			end
			ACT_DATA: begin
				q_tk.kind  = TK_OCT;
				q_tk.octet = data_q;
			end
			ACT_HDR: begin
				q_tk.kind  = TK_OCT;
				q_tk.octet = hdr_oct;
				tk_last    = (idx_q == I_HDR_END);
			end
			ACT_END: begin
				if (idx_q == IDX_W'(0))
					q_tk.kind = TK_FCS_LO;
				else if (idx_q == IDX_W'(1))
					q_tk.kind = TK_FCS_HI;
				else
					q_tk.kind = TK_END;
				tk_last = (idx_q == IDX_W'(2));
			end
			default: ;
		endcase
	end

	assign q_push   = busy_q && !q_full;
	assign s_tready = !busy_q || (q_push && tk_last);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (q_push) begin
			busy_q <= !tk_last;
			idx_q  <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= action_t'(s_tuser);
			data_q <= s_tdata;
		end
	end

endmodule

// ===== src/hfte_fifo.sv =====
module hfte_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  hfte_pkg::tk_word_t din,
	output logic               full,
	output logic               valid,
	output hfte_pkg::tk_word_t dout,
	input  logic               pop
);
	import hfte_pkg::*;

	tk_word_t             mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_q;
	logic [Q_PTR_W-1:0]   rd_q;
	logic [Q_PTR_W:0]     cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = (cnt_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign valid   = (cnt_q != '0);
	assign dout    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + Q_PTR_W'(1);
			if (do_pop)
				rd_q <= rd_q + Q_PTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + (Q_PTR_W+1)'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - (Q_PTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= din;
	end

endmodule

// ===== src/hfte_back.sv =====
module hfte_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  hfte_pkg::tk_word_t q_tk,
	output logic               q_pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,
	output logic               m_tlast
);
	import hfte_pkg::*;

	bk_state_t   state_q, state_d;
	tk_kind_t    kind_q, kind_d;
	logic [7:0]  sh_q, sh_d;
	logic [2:0]  bit_q, bit_d;
	logic [2:0]  ones_q, ones_d;
	logic        lvl_q, lvl_d;
	logic [15:0] crc_q, crc_d;
	logic        open_q, open_d;
	logic [7:0]  pack_q, pack_d;
	logic [2:0]  pcnt_q, pcnt_d;

	logic        out_v_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;

	logic        push, plev, lvl_new;
	logic        pop, finish, close, stuff_now, last_lvl, emit, stall;

	// one line level per cycle, held while the output word stalls
	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		sh_d      = sh_q;
		bit_d     = bit_q;
		ones_d    = ones_q;
		lvl_d     = lvl_q;
		crc_d     = crc_q;
		open_d    = open_q;
		push      = 1'b0;
		plev      = 1'b0;
		lvl_new   = lvl_q;
		pop       = 1'b0;
		finish    = 1'b0;
		close     = 1'b0;
		stuff_now = 1'b0;
		last_lvl  = 1'b0;

		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					pop     = 1'b1;
					kind_d  = q_tk.kind;
					sh_d    = tk_octet(q_tk, open_q ? crc_q : CRC_INIT);
					bit_d   = '0;
					state_d = open_q ? BK_BITS : BK_OPEN;
				end
			end
			BK_OPEN: begin
				// leading level 0 of a new frame
				push    = 1'b1;
				plev    = 1'b0;
				lvl_d   = 1'b0;
				crc_d   = CRC_INIT;
				ones_d  = '0;
				open_d  = 1'b1;
				state_d = BK_BITS;
			end
			BK_BITS: begin
				lvl_new = sh_q[0] ? lvl_q : ~lvl_q;
				push    = 1'b1;
				plev    = lvl_new;
				lvl_d   = lvl_new;
				sh_d    = {1'b0, sh_q[7:1]};
				bit_d   = bit_q + 3'd1;
				if (kind_q == TK_OCT)
					crc_d = {1'b0, crc_q[15:1]} ^ ((crc_q[0] ^ sh_q[0]) ? CRC_POLY : '0);
				// flags go out unstuffed and clear the run
				if (kind_q == TK_FLAG || kind_q == TK_END)
					ones_d = '0;
				else if (sh_q[0]) begin
					if (ones_q == STUFF_RUN - 3'd1) begin
						stuff_now = 1'b1;
						ones_d    = '0;
					end else begin
						ones_d = ones_q + 3'd1;
					end
				end else begin
					ones_d = '0;
				end
				if (stuff_now)
					state_d = BK_STUFF;
				else if (bit_q == 3'd7)
					finish = 1'b1;
				last_lvl = (kind_q == TK_END) && (bit_q == 3'd7);
			end
			BK_STUFF: begin
				lvl_new = ~lvl_q;
				push    = 1'b1;
				plev    = lvl_new;
				lvl_d   = lvl_new;
				// bit counter wraps to zero once all eight bits are out
				if (bit_q == 3'd0)
					finish = 1'b1;
				else
					state_d = BK_BITS;
			end
			BK_PAD: begin
				push     = 1'b1;
				plev     = 1'b1;
				last_lvl = 1'b1;
				if (pcnt_q == 3'd7)
					close = 1'b1;
			end
			default: state_d = BK_IDLE;
		endcase

		// byte packer, MSB first
		pack_d = pack_q;
		pcnt_d = pcnt_q;
		emit   = 1'b0;
		if (push) begin
			pack_d = {pack_q[6:0], plev};
			pcnt_d = pcnt_q + 3'd1;
			emit   = (pcnt_q == 3'd7);
		end

		// octet done: close or pad the frame end, else chain the next job or go idle
		if (finish) begin
			if (kind_q == TK_END) begin
				if (pcnt_d == 3'd0)
					close = 1'b1;
				else
					state_d = BK_PAD;
			end else if (q_valid) begin
				pop     = 1'b1;
				kind_d  = q_tk.kind;
				sh_d    = tk_octet(q_tk, crc_d);
				bit_d   = '0;
				state_d = BK_BITS;
			end else begin
				state_d = BK_IDLE;
			end
		end

		if (close) begin
			state_d = BK_IDLE;
			open_d  = 1'b0;
			crc_d   = CRC_INIT;
			ones_d  = '0;
			lvl_d   = 1'b0;
		end
	end

	assign stall = emit && out_v_q && !m_tready;
	assign q_pop = pop && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			bit_q   <= '0;
			ones_q  <= '0;
			lvl_q   <= 1'b0;
			crc_q   <= CRC_INIT;
			open_q  <= 1'b0;
			pcnt_q  <= '0;
		end else if (!stall) begin
			state_q <= state_d;
			bit_q   <= bit_d;
			ones_q  <= ones_d;
			lvl_q   <= lvl_d;
			crc_q   <= crc_d;
			open_q  <= open_d;
			pcnt_q  <= pcnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			kind_q <= kind_d;
			sh_q   <= sh_d;
			pack_q <= pack_d;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (emit && !stall)
			out_v_q <= 1'b1;
		else if (m_tready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit && !stall) begin
			out_byte_q <= pack_d;
			out_last_q <= last_lvl;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;

	a_pad_in_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_PAD |-> kind_q == TK_END && open_q)
		else $error("padding outside a frame end");

	a_closed_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |-> pcnt_q == 3'd0 && ones_q == 3'd0)
		else $error("closed frame left packer or stuffer state");

	a_stuff_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_STUFF |-> ones_q == 3'd0)
		else $error("ones run not cleared on stuffed zero");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !stall && last_lvl |=> !open_q && state_q == BK_IDLE)
		else $error("frame still open after its last word");

endmodule

// ===== src/hdlc_frame_transmit_encoder.sv =====
// The back end codes one line level per clock save while the output word stalls; an
// octet is eight levels plus one per stuffed zero, and a new frame opens with a level 0.
// A header command makes 2*CALLSIGN_CHARS+4 octets (16 by default), an end command FCS,
// flag and pad. When the 4-entry octet queue runs empty, the back end goes idle.
// A command is taken once the last one is fully queued, also while a word waits.
// Reset (arst_n low, asynchronous) empties the queue, closes any frame, restores registers.
module hdlc_frame_transmit_encoder #(
	parameter int CALLSIGN_CHARS = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hfte_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hfte_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] data_byte
	input  logic [1:0]                     s_tuser,   // [1:0] action
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,   // [7:0] line_byte
	output logic                           m_tlast
);
	import hfte_pkg::*;

	tk_word_t push_tk;
	tk_word_t head_tk;
	logic     q_push;
	logic     q_full;
	logic     q_valid;
	logic     q_pop;

	hfte_front #(
		.CALLSIGN_CHARS(CALLSIGN_CHARS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_tk     (push_tk)
	);

	hfte_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (push_tk),
		.full  (q_full),
		.valid (q_valid),
		.dout  (head_tk),
		.pop   (q_pop)
	);

	hfte_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_tk    (head_tk),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int          CS_CHARS   = 6;
	localparam logic [15:0] FCS_SEED   = 16'hFFFF;
	localparam logic [15:0] FCS_POLY   = 16'h8408;   // 0x1021 bit-reversed
	localparam logic [7:0]  HDLC_FLAG  = 8'h7E;
	localparam int          RUN_LIMIT  = 800000;
	localparam int          SETTLE     = 40;

	typedef struct {
		hfte_pkg::action_t act;
		logic [7:0]        data;
	} command_t;

	typedef struct {
		logic [7:0] levels;
		logic       last;
	} line_word_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [hfte_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [hfte_pkg::CFG_W-1:0]     cfg_data;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [7:0]                     s_tdata;   // [7:0] data_byte
	logic [1:0]                     s_tuser;   // [1:0] action
	logic                           m_tvalid;
	logic                           m_tready;
	logic [7:0]                     m_tdata;   // [7:0] line_byte
	logic                           m_tlast;

	hdlc_frame_transmit_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// commands waiting for the driver, line words still owed by the block
	command_t   pending_cmds[$];
	line_word_t line_words_due[$];

	int   errors     = 0;
	int   n_queued   = 0;
	int   n_accepted = 0;
	int   cycles     = 0;
	logic steady     = 1'b0;   // no idling on either side

	// register shadow
	logic [47:0] sh_dest_cs, sh_src_cs;
	logic [7:0]  sh_dest_id, sh_src_id, sh_ctrl, sh_pid;

	// framer state
	logic [15:0] fcs_reg;
	logic [2:0]  ones_seen;
	logic        nrzi_level;
	logic [7:0]  shift_bits;
	logic [3:0]  shift_count;
	logic        in_frame;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Framer prediction
	// ---------------------------------------------------------------

	function automatic void put_level(logic lvl);
		shift_bits  = {shift_bits[6:0], lvl};
		shift_count = shift_count + 4'd1;
		if (shift_count == 4'd8) begin
			line_words_due.push_back('{levels: shift_bits, last: 1'b0});
			shift_bits  = '0;
			shift_count = '0;
		end
	endfunction

	// NRZI: a zero toggles the line
	function automatic void nrzi_bit(logic b);
		if (!b)
			nrzi_level = ~nrzi_level;
		put_level(nrzi_level);
	endfunction

	function automatic void stuffed_bit(logic b);
		nrzi_bit(b);
		if (b) begin
			ones_seen = ones_seen + 3'd1;
			if (ones_seen >= 3'd5) begin
				nrzi_bit(1'b0);
				ones_seen = '0;
			end
		end else begin
			ones_seen = '0;
		end
	endfunction

	// LSB first; the FCS octets themselves are kept out of the CRC
	function automatic void send_octet(logic [7:0] v, logic fold_crc);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			if (fold_crc) begin
				fb      = fcs_reg[0] ^ v[i];
				fcs_reg = fcs_reg >> 1;
				if (fb)
					fcs_reg = fcs_reg ^ FCS_POLY;
			end
			stuffed_bit(v[i]);
		end
	endfunction

	function automatic void send_flag();
		for (int i = 7; i >= 0; i--)
			nrzi_bit(HDLC_FLAG[i]);
		ones_seen = '0;
	endfunction

	function automatic void send_callsign(logic [47:0] cs);
		logic [7:0] ch;
		for (int i = 0; i < CS_CHARS; i++) begin
			ch = cs[40 - 8 * i +: 8];
			send_octet({ch[6:0], 1'b0}, 1'b1);
		end
	endfunction

	function automatic void framer_reset_state();
		fcs_reg     = FCS_SEED;
		ones_seen   = '0;
		nrzi_level  = 1'b0;
		shift_bits  = '0;
		shift_count = '0;
		in_frame    = 1'b0;
	endfunction

	function automatic void encode_command(hfte_pkg::action_t act, logic [7:0] data);
		int         n_before;
		logic [15:0] fcs;
		n_before = line_words_due.size();
		// any command opens a frame, led by one level 0
		if (!in_frame) begin
			in_frame   = 1'b1;
			nrzi_level = 1'b0;
			fcs_reg    = FCS_SEED;
			ones_seen  = '0;
			put_level(1'b0);
		end
		case (act)
			hfte_pkg::ACT_FLAG: begin
				send_flag();
			end
			hfte_pkg::ACT_HDR: begin
				send_callsign(sh_dest_cs);
				send_octet(sh_dest_id, 1'b1);
				send_callsign(sh_src_cs);
				send_octet(sh_src_id, 1'b1);
				send_octet(sh_ctrl, 1'b1);
				send_octet(sh_pid, 1'b1);
			end
			hfte_pkg::ACT_DATA: begin
				send_octet(data, 1'b1);
			end
			default: begin
				fcs = ~fcs_reg;
				send_octet(fcs[7:0], 1'b0);
				send_octet(fcs[15:8], 1'b0);
				send_flag();
				while (shift_count != 0)
					put_level(1'b1);
				if (line_words_due.size() > n_before)
					line_words_due[line_words_due.size() - 1].last = 1'b1;
				framer_reset_state();
			end
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	task automatic add_cmd(hfte_pkg::action_t act, logic [7:0] data);
		pending_cmds.push_back('{act: act, data: data});
		n_queued++;
	endtask

	task automatic reg_write(logic [hfte_pkg::CFG_IDX_W-1:0] idx, logic [47:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			hfte_pkg::REG_DEST_CS: sh_dest_cs = val;
			hfte_pkg::REG_SRC_CS:  sh_src_cs  = val;
			hfte_pkg::REG_DEST_ID: sh_dest_id = val[7:0];
			hfte_pkg::REG_SRC_ID:  sh_src_id  = val[7:0];
			hfte_pkg::REG_CTRL:    sh_ctrl    = val[7:0];
			hfte_pkg::REG_PID:     sh_pid     = val[7:0];
			default: ;
		endcase
	endtask

	function automatic logic [47:0] pick_callsign(int style);
		logic [47:0] cs;
		case (style)
			0:       cs = '1;
			1:       cs = '0;
			2: begin
				for (int i = 0; i < 6; i++)
					cs[8 * i +: 8] = 8'($urandom_range(8'h20, 8'h5A));
			end
			default: cs = {16'($urandom), 32'($urandom)};
		endcase
		return cs;
	endfunction

	function automatic logic [7:0] pick_octet(int style);
		case (style)
			0:       return 8'hFF;
			1:       return 8'h00;
			default: return 8'($urandom);
		endcase
	endfunction

	// payload leaning towards long runs of ones for the stuffer
	function automatic logic [7:0] pick_payload();
		if ($urandom_range(0, 3) == 0)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	// everything taken, everything seen, then the back end left to drain
	task automatic wait_quiet();
		while (n_accepted != n_queued || line_words_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------

	initial begin : stimulus
		int                style;
		int                phase;
		int                n_rand;
		int                n_data;
		hfte_pkg::action_t last_act;

		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		m_tready  = 1'b0;

		sh_dest_cs = '0;
		sh_src_cs  = '0;
		sh_dest_id = '0;
		sh_src_id  = '0;
		sh_ctrl    = hfte_pkg::CTRL_RESET;
		sh_pid     = hfte_pkg::PID_RESET;
		framer_reset_state();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset registers, empty frame, stuffing runs, ignored data
		add_cmd(hfte_pkg::ACT_END,  8'h00);
		add_cmd(hfte_pkg::ACT_FLAG, 8'h00);
		add_cmd(hfte_pkg::ACT_FLAG, 8'hFF);
		add_cmd(hfte_pkg::ACT_HDR,  8'hA5);
		add_cmd(hfte_pkg::ACT_DATA, 8'h00);
		add_cmd(hfte_pkg::ACT_DATA, 8'hFF);
		add_cmd(hfte_pkg::ACT_DATA, 8'h7E);
		add_cmd(hfte_pkg::ACT_DATA, 8'h01);
		add_cmd(hfte_pkg::ACT_DATA, 8'h80);
		add_cmd(hfte_pkg::ACT_DATA, 8'hFF);
		add_cmd(hfte_pkg::ACT_DATA, 8'hFF);
		add_cmd(hfte_pkg::ACT_END,  8'hFF);
		add_cmd(hfte_pkg::ACT_DATA, 8'h55);
		add_cmd(hfte_pkg::ACT_END,  8'h5A);
		add_cmd(hfte_pkg::ACT_HDR,  8'hFF);
		add_cmd(hfte_pkg::ACT_FLAG, 8'h3C);
		add_cmd(hfte_pkg::ACT_END,  8'h00);
		wait_quiet();

		// random phases, each with its own register setting
		n_rand = 0;
		phase  = 0;
		while (n_rand < 320) begin
			style = phase % 5;
			reg_write(hfte_pkg::REG_DEST_CS, pick_callsign(style));
			reg_write(hfte_pkg::REG_SRC_CS,  pick_callsign(style));
			reg_write(hfte_pkg::REG_DEST_ID, {40'd0, pick_octet(style)});
			reg_write(hfte_pkg::REG_SRC_ID,  {40'd0, pick_octet(style)});
			reg_write(hfte_pkg::REG_CTRL,    {40'd0, pick_octet(style)});
			reg_write(hfte_pkg::REG_PID,     {40'd0, pick_octet(style)});
			@(posedge clk);
			cfg_we <= 1'b0;
			steady = (phase % 4 == 3);

			last_act = hfte_pkg::ACT_END;
			for (int f = $urandom_range(2, 4); f > 0; f--) begin
				if ($urandom_range(0, 5) == 0) begin
					// noise: anything in any order, frame may stay open
					for (int k = $urandom_range(1, 6); k > 0; k--) begin
						last_act = hfte_pkg::action_t'($urandom_range(0, 3));
						add_cmd(last_act, 8'($urandom));
					end
				end else begin
					for (int k = $urandom_range(0, 2); k > 0; k--)
						add_cmd(hfte_pkg::ACT_FLAG, 8'($urandom));
					if ($urandom_range(0, 7) != 0)
						add_cmd(hfte_pkg::ACT_HDR, 8'($urandom));
					n_data = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
					                                     : $urandom_range(0, 8);
					for (int k = 0; k < n_data; k++)
						add_cmd(hfte_pkg::ACT_DATA, pick_payload());
					last_act = hfte_pkg::ACT_END;
					add_cmd(last_act, 8'($urandom));
				end
			end
			// close the frame so the block is idle for the next register writes
			if (last_act != hfte_pkg::ACT_END)
				add_cmd(hfte_pkg::ACT_END, 8'($urandom));
			n_rand = n_queued - 17;
			wait_quiet();
			phase++;
		end

		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// ---------------------------------------------------------------
	// Command driver: bursts with random gaps
	// ---------------------------------------------------------------

	always @(posedge clk) begin : driver
		int       burst_left;
		int       gap_left;
		command_t nxt;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				encode_command(hfte_pkg::action_t'(s_tuser), s_tdata);
				n_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0 && !steady) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_cmds.size() != 0) begin
					nxt = pending_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= nxt.act;
					s_tdata  <= nxt.data;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Line monitor and receiver stalls
	// ---------------------------------------------------------------

	always @(posedge clk) begin : monitor
		logic [31:0] stall_pat;
		logic [4:0]  pat_age;
		line_word_t  w;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (line_words_due.size() == 0) begin
					$display("%0t: unexpected line word %02h last %0b", $time, m_tdata, m_tlast);
					errors++;
				end else begin
					w = line_words_due.pop_front();
					if (m_tdata !== w.levels) begin
						$display("%0t: line_byte expected %02h actual %02h",
						         $time, w.levels, m_tdata);
						errors++;
					end
					if (m_tlast !== w.last) begin
						$display("%0t: frame_last expected %0b actual %0b",
						         $time, w.last, m_tlast);
						errors++;
					end
				end
			end
			// new pattern each time the 5-bit age counter wraps; now and then one long stall
			pat_age = pat_age + 5'd1;
			if (pat_age == 0)
				stall_pat = ($urandom_range(0, 5) == 0) ? 32'd0 : ($urandom | $urandom);
			else
				stall_pat = {stall_pat[0], stall_pat[31:1]};
			m_tready <= steady || stall_pat[0];
		end else begin
			stall_pat = '1;
			pat_age   = '0;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= RUN_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule
